// ----- sv/mtrc_pkg.sv -----
// shared constants and types for the modbus tcp response checker
`default_nettype none
package mtrc_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 260;
	localparam int unsigned POS_W = 9;

	localparam logic [7:0] FN_READ  = 8'd3;
	localparam logic [7:0] FN_WRITE = 8'd16;
	localparam logic [7:0] EXC_BIT  = 8'h80;
	localparam logic [7:0] UNIT_ID_RESET = 8'd1;

	localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_LEN_LO = 9'd4;
	localparam logic [POS_W-1:0] POS_LEN_HI = 9'd5;
	localparam logic [POS_W-1:0] POS_UNIT   = 9'd6;
	localparam logic [POS_W-1:0] POS_FUNC   = 9'd7;
	localparam logic [POS_W-1:0] POS_BCNT   = 9'd8;
	localparam logic [POS_W-1:0] POS_ADR_LO = 9'd9;
	localparam logic [POS_W-1:0] POS_CNT_HI = 9'd10;
	localparam logic [POS_W-1:0] POS_CNT_LO = 9'd11;
	localparam logic [POS_W-1:0] POS_MIN_LEN = 9'd7;
	localparam logic [POS_W-1:0] POS_RD_EXTRA = 9'd9;
	localparam logic [POS_W-1:0] POS_WR_LEN = 9'd12;
	localparam logic [15:0] LEN_HDR = 16'd6;

	typedef logic [3:0] status_t;

	localparam status_t ST_OK       = 4'd0;
	localparam status_t ST_NO_RESP  = 4'd1;
	localparam status_t ST_BAD_ADDR = 4'd2;
	localparam status_t ST_BAD_EXC  = 4'd3;
	localparam status_t ST_EXC      = 4'd4;
	localparam status_t ST_FUNC     = 4'd5;
	localparam status_t ST_COUNT    = 4'd6;
	localparam status_t ST_LENGTH   = 4'd7;
	localparam status_t ST_ZERO     = 4'd8;
	localparam status_t ST_UNSUP    = 4'd9;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic        last_byte;
		logic [7:0]  expected_function;
		logic [15:0] reg_address;
		logic [6:0]  reg_count;
	} item_t;

endpackage
`default_nettype wire

// ----- sv/modbus_tcp_response_checker.sv -----
// modbus tcp response checker top level: byte-wise header and data checks
//
// channel   direction  transaction
// s_*       in         one response byte with its request fields
// m_*       out        one data word and/or the frame status
// cfg_*     in         expected unit id
//
// one byte per cycle while the output is not stalled; each byte is held in the input
// register and its result is registered into the output register.
// a byte that gives no result never waits on m_tready.
// arst_n clears frame state and sets unit id to 1.
// a stalled output holds one byte in the input register, then s_tready drops.
`default_nettype none
module modbus_tcp_response_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// rx_byte[7:0], expected_function[15:8], reg_address[31:16], reg_count[38:32]
	input  wire logic [39:0] s_tdata,
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// data_word[15:0], status[19:16], exception_code[27:20]
	output logic      [31:0] m_tdata,
	// word_valid[0]
	output logic             m_tuser,
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	logic                 valid_s1;
	mtrc_pkg::item_t      item_s1;
	logic                 adv_s1;
	logic                 res_s1;

	logic [7:0]           unit_id_q;
	logic [mtrc_pkg::POS_W-1:0] pos_q;
	logic [7:0]           pend_q;
	logic                 hdr_nz_q;
	logic [15:0]          len_q;
	logic                 unit_mis_q;
	logic [7:0]           rfn_q;
	logic [7:0]           bcnt_q;
	logic [15:0]          echo_adr_q;
	logic [15:0]          echo_cnt_q;

	logic [mtrc_pkg::POS_W-1:0] pos_n;
	logic [7:0]           pend_n;
	logic                 hdr_nz_n;
	logic [15:0]          len_n;
	logic                 unit_mis_n;
	logic [7:0]           rfn_n;
	logic [7:0]           bcnt_n;
	logic [15:0]          echo_adr_n;
	logic [15:0]          echo_cnt_n;
	logic                 wv;
	logic [15:0]          word;
	logic [mtrc_pkg::POS_W-1:0] widx;
	mtrc_pkg::status_t    st;
	logic [7:0]           exc;
	logic [7:0]           b;
	logic [7:0]           fn;
	logic [6:0]           cnt;

	logic                 out_valid_q;
	logic [15:0]          out_word_q;
	logic                 out_wv_q;
	logic                 out_last_q;
	mtrc_pkg::status_t    out_st_q;
	logic [7:0]           out_exc_q;

	assign b   = item_s1.rx_byte;
	assign fn  = item_s1.expected_function;
	assign cnt = item_s1.reg_count;

	assign cfg_ready = 1'b1;
	assign res_s1    = wv || item_s1.last_byte;
	assign adv_s1    = valid_s1 && (!res_s1 || !out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.rx_byte           <= s_tdata[7:0];
			item_s1.last_byte         <= s_tlast;
			item_s1.expected_function <= s_tdata[15:8];
			item_s1.reg_address       <= s_tdata[31:16];
			item_s1.reg_count         <= s_tdata[38:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_id_q <= mtrc_pkg::UNIT_ID_RESET;
		end else if (cfg_valid) begin
			unit_id_q <= cfg_data;
		end
	end

	// frame field capture
	always_comb begin
		pos_n      = pos_q;
		pend_n     = pend_q;
		hdr_nz_n   = hdr_nz_q;
		len_n      = len_q;
		unit_mis_n = unit_mis_q;
		rfn_n      = rfn_q;
		bcnt_n     = bcnt_q;
		echo_adr_n = echo_adr_q;
		echo_cnt_n = echo_cnt_q;
		wv         = 1'b0;
		word       = 16'd0;
		widx       = (pos_q - mtrc_pkg::POS_CNT_HI) >> 1;
		if (pos_q < mtrc_pkg::POS_MAX) begin
			pos_n = pos_q + 9'd1;
			if (pos_q < mtrc_pkg::POS_LEN_LO) begin
				if (b != 8'd0) begin
					hdr_nz_n = 1'b1;
				end
			end else if (pos_q == mtrc_pkg::POS_LEN_LO) begin
				len_n = {b, 8'd0};
			end else if (pos_q == mtrc_pkg::POS_LEN_HI) begin
				len_n = {len_q[15:8], b};
			end else if (pos_q == mtrc_pkg::POS_UNIT) begin
				unit_mis_n = (b != unit_id_q);
			end else if (pos_q == mtrc_pkg::POS_FUNC) begin
				rfn_n = b;
			end else begin
				if (pos_q == mtrc_pkg::POS_BCNT) begin
					bcnt_n     = b;
					echo_adr_n = {b, 8'd0};
				end else if (pos_q == mtrc_pkg::POS_ADR_LO) begin
					echo_adr_n = {echo_adr_q[15:8], b};
				end else if (pos_q == mtrc_pkg::POS_CNT_HI) begin
					echo_cnt_n = {b, 8'd0};
				end else if (pos_q == mtrc_pkg::POS_CNT_LO) begin
					echo_cnt_n = {echo_cnt_q[15:8], b};
				end
				if (pos_q >= mtrc_pkg::POS_ADR_LO) begin
					if (pos_q[0]) begin
						pend_n = b;
					end else if (fn == mtrc_pkg::FN_READ && rfn_q == mtrc_pkg::FN_READ
							&& widx < {2'd0, cnt}) begin
						wv   = 1'b1;
						word = {pend_q, b};
					end
				end
			end
		end
	end

	// frame status in check order
	always_comb begin
		exc = 8'd0;
		if (fn != mtrc_pkg::FN_READ && fn != mtrc_pkg::FN_WRITE) begin
			st = mtrc_pkg::ST_UNSUP;
		end else if (cnt == 7'd0) begin
			st = mtrc_pkg::ST_ZERO;
		end else if (pos_n < mtrc_pkg::POS_MIN_LEN) begin
			st = mtrc_pkg::ST_NO_RESP;
		end else if (hdr_nz_n) begin
			st = mtrc_pkg::ST_NO_RESP;
		end else if (len_n != {7'd0, pos_n} - mtrc_pkg::LEN_HDR) begin
			st = mtrc_pkg::ST_NO_RESP;
		end else if (unit_mis_n) begin
			st = mtrc_pkg::ST_BAD_ADDR;
		end else if ((rfn_n & mtrc_pkg::EXC_BIT) != 8'd0) begin
			if ((rfn_n & ~mtrc_pkg::EXC_BIT) != fn) begin
				st = mtrc_pkg::ST_BAD_EXC;
			end else begin
				st  = mtrc_pkg::ST_EXC;
				exc = bcnt_n;
			end
		end else if (rfn_n != fn) begin
			st = mtrc_pkg::ST_FUNC;
		end else if (fn == mtrc_pkg::FN_READ) begin
			if (bcnt_n != {cnt, 1'b0}) begin
				st = mtrc_pkg::ST_COUNT;
			end else if (pos_n != {1'b0, cnt, 1'b0} + mtrc_pkg::POS_RD_EXTRA) begin
				st = mtrc_pkg::ST_LENGTH;
			end else begin
				st = mtrc_pkg::ST_OK;
			end
		end else begin
			if (pos_n != mtrc_pkg::POS_WR_LEN) begin
				st = mtrc_pkg::ST_LENGTH;
			end else if (echo_adr_n != item_s1.reg_address) begin
				st = mtrc_pkg::ST_BAD_ADDR;
			end else if (echo_cnt_n != {9'd0, cnt}) begin
				st = mtrc_pkg::ST_COUNT;
			end else begin
				st = mtrc_pkg::ST_OK;
			end
		end
	end

	// frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			pend_q     <= '0;
			hdr_nz_q   <= 1'b0;
			len_q      <= '0;
			unit_mis_q <= 1'b0;
			rfn_q      <= '0;
			bcnt_q     <= '0;
			echo_adr_q <= '0;
			echo_cnt_q <= '0;
		end else if (adv_s1) begin
			if (item_s1.last_byte) begin
				pos_q      <= '0;
				pend_q     <= '0;
				hdr_nz_q   <= 1'b0;
				len_q      <= '0;
				unit_mis_q <= 1'b0;
				rfn_q      <= '0;
				bcnt_q     <= '0;
				echo_adr_q <= '0;
				echo_cnt_q <= '0;
			end else begin
				pos_q      <= pos_n;
				pend_q     <= pend_n;
				hdr_nz_q   <= hdr_nz_n;
				len_q      <= len_n;
				unit_mis_q <= unit_mis_n;
				rfn_q      <= rfn_n;
				bcnt_q     <= bcnt_n;
				echo_adr_q <= echo_adr_n;
				echo_cnt_q <= echo_cnt_n;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_s1) begin
			out_word_q <= word;
			out_wv_q   <= wv;
			out_last_q <= item_s1.last_byte;
			out_st_q   <= item_s1.last_byte ? st : mtrc_pkg::ST_OK;
			out_exc_q  <= item_s1.last_byte ? exc : 8'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_exc_q, out_st_q, out_word_q};
	assign m_tuser  = out_wv_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser || m_tlast))
		else $error("result without word or frame end");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[27:16] == 12'd0))
		else $error("status before frame end");

	a_exc_code_with_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[27:20] != 8'd0) |-> (m_tdata[19:16] == mtrc_pkg::ST_EXC))
		else $error("exception code without exception status");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= mtrc_pkg::POS_MAX)
		else $error("byte position beyond frame limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && item_s1.last_byte) |=> (pos_q == '0 && !hdr_nz_q))
		else $error("frame state not cleared after last byte");
`endif

endmodule
`default_nettype wire

// ----- sim/modbus_tcp_response_checker_tb.sv -----
// testbench for the modbus tcp response checker: byte-wise frame stimulus and a reply scoreboard
module modbus_tcp_response_checker_tb;

	localparam int ITEMS_PER_PHASE = 240;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		logic [15:0]       data_word;
		logic              word_valid;
		logic              done;
		mtrc_pkg::status_t status;
		logic [7:0]        exc_code;
	} reply_t;

	class resp_scoreboard;
		reply_t      want_q[$];
		logic [7:0]  unit_id;
		logic [8:0]  pos;
		logic [7:0]  hi_byte;
		logic        id_nz;
		logic [15:0] len_field;
		logic        unit_bad;
		logic [7:0]  rsp_fn;
		logic [7:0]  bcnt;
		logic [15:0] echo_addr;
		logic [15:0] echo_cnt;
		int          errors;

		function new();
			unit_id = mtrc_pkg::UNIT_ID_RESET;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			pos = '0;
			hi_byte = '0;
			id_nz = 1'b0;
			len_field = '0;
			unit_bad = 1'b0;
			rsp_fn = '0;
			bcnt = '0;
			echo_addr = '0;
			echo_cnt = '0;
		endfunction

		function void set_unit(input logic [7:0] v);
			unit_id = v;
		endfunction

		function mtrc_pkg::status_t frame_status(input logic [7:0] fn,
				input logic [15:0] addr, input logic [6:0] cnt, output logic [7:0] code);
			int len;
			len = int'(pos);
			code = '0;
			if (fn != mtrc_pkg::FN_READ && fn != mtrc_pkg::FN_WRITE)
				return mtrc_pkg::ST_UNSUP;
			if (cnt == '0) return mtrc_pkg::ST_ZERO;
			if (len < 7) return mtrc_pkg::ST_NO_RESP;
			if (id_nz) return mtrc_pkg::ST_NO_RESP;
			if (len_field != 16'(len - 6)) return mtrc_pkg::ST_NO_RESP;
			if (unit_bad) return mtrc_pkg::ST_BAD_ADDR;
			if ((rsp_fn & mtrc_pkg::EXC_BIT) != '0) begin
				if ((rsp_fn & ~mtrc_pkg::EXC_BIT) != fn) return mtrc_pkg::ST_BAD_EXC;
				code = bcnt;
				return mtrc_pkg::ST_EXC;
			end
			if (rsp_fn != fn) return mtrc_pkg::ST_FUNC;
			if (fn == mtrc_pkg::FN_READ) begin
				if (bcnt != 8'(int'(cnt) * 2)) return mtrc_pkg::ST_COUNT;
				if (len - 7 != int'(cnt) * 2 + 2) return mtrc_pkg::ST_LENGTH;
			end else begin
				if (len - 7 != 5) return mtrc_pkg::ST_LENGTH;
				if (echo_addr != addr) return mtrc_pkg::ST_BAD_ADDR;
				if (echo_cnt != {9'b0, cnt}) return mtrc_pkg::ST_COUNT;
			end
			return mtrc_pkg::ST_OK;
		endfunction

		function void note_byte(input mtrc_pkg::item_t it);
			logic [8:0] p;
			logic [7:0] b;
			reply_t r;
			p = pos;
			b = it.rx_byte;
			r.data_word = '0;
			r.word_valid = 1'b0;
			r.done = it.last_byte;
			r.status = mtrc_pkg::ST_OK;
			r.exc_code = '0;
			if (p < mtrc_pkg::MAX_FRAME_BYTES) begin
				if (p < 4) begin
					if (b != '0) id_nz = 1'b1;
				end else if (p == 4) begin
					len_field = {b, 8'h00};
				end else if (p == 5) begin
					len_field = len_field | {8'h00, b};
				end else if (p == 6) begin
					unit_bad = (b != unit_id);
				end else if (p == 7) begin
					rsp_fn = b;
				end else begin
					if (p == 8) begin
						bcnt = b;
						echo_addr = {b, 8'h00};
					end else if (p == 9) begin
						echo_addr = echo_addr | {8'h00, b};
					end else if (p == 10) begin
						echo_cnt = {b, 8'h00};
					end else if (p == 11) begin
						echo_cnt = echo_cnt | {8'h00, b};
					end
					if (p >= 9) begin
						if (p[0]) begin
							hi_byte = b;
						end else if (it.expected_function == mtrc_pkg::FN_READ
								&& rsp_fn == mtrc_pkg::FN_READ
								&& ((int'(p) - 10) >> 1) < int'(it.reg_count)) begin
							r.word_valid = 1'b1;
							r.data_word = {hi_byte, b};
						end
					end
				end
				pos = p + 9'd1;
			end
			if (!r.word_valid && !it.last_byte) return;
			if (it.last_byte) begin
				r.status = frame_status(it.expected_function, it.reg_address, it.reg_count,
					r.exc_code);
				clear_frame();
			end
			want_q.push_back(r);
		endfunction

		function void check_reply(input reply_t got);
			reply_t w;
			if (want_q.size() == 0) begin
				errors++;
				$error("reply with nothing pending: data_word %h status %0d", got.data_word,
					got.status);
				return;
			end
			w = want_q.pop_front();
			if (got.data_word !== w.data_word) begin
				errors++;
				$error("data_word: expected %h, got %h", w.data_word, got.data_word);
			end
			if (got.word_valid !== w.word_valid) begin
				errors++;
				$error("word_valid: expected %0d, got %0d", w.word_valid, got.word_valid);
			end
			if (got.done !== w.done) begin
				errors++;
				$error("done_res: expected %0d, got %0d", w.done, got.done);
			end
			if (got.status !== w.status) begin
				errors++;
				$error("status: expected %0d, got %0d", w.status, got.status);
			end
			if (got.exc_code !== w.exc_code) begin
				errors++;
				$error("exception_code: expected %h, got %h", w.exc_code, got.exc_code);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	resp_scoreboard sb;
	logic [7:0] frame_q[$];
	logic [7:0] cur_unit;
	bit         idle_on = 1'b1;
	int         items_sent;
	int         quiet_cycles = 0;

	modbus_tcp_response_checker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= !idle_on || ($urandom_range(0, 99) >= 26);
	end

	always @(posedge clk) begin
		reply_t          got;
		mtrc_pkg::item_t it;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.data_word = m_tdata[15:0];
				got.status = m_tdata[19:16];
				got.exc_code = m_tdata[27:20];
				got.word_valid = m_tuser;
				got.done = m_tlast;
				sb.check_reply(got);
			end
			if (s_tvalid && s_tready) begin
				it.rx_byte = s_tdata[7:0];
				it.expected_function = s_tdata[15:8];
				it.reg_address = s_tdata[31:16];
				it.reg_count = s_tdata[38:32];
				it.last_byte = s_tlast;
				sb.note_byte(it);
			end
			if (cfg_valid && cfg_ready) sb.set_unit(cfg_data);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic drain();
		while (sb.want_q.size() != 0) @(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] fn, input logic [15:0] addr,
			input logic [6:0] cnt, input bit mixed);
		logic [7:0] f;
		logic [6:0] c;
		for (int i = 0; i < frame_q.size(); i++) begin
			f = fn;
			c = cnt;
			if (mixed && i != frame_q.size() - 1 && $urandom_range(0, 3) == 0) begin
				f = 8'($urandom_range(0, 255));
				c = 7'($urandom_range(0, 125));
			end
			while (idle_on && $urandom_range(0, 99) < 26) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
			s_tvalid = 1'b1;
			s_tdata = {1'b0, c, addr, f, frame_q[i]};
			s_tlast = (i == frame_q.size() - 1);
			do @(posedge clk); while (!s_tready);
			@(negedge clk);
			items_sent++;
		end
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
	endtask

	task automatic write_unit(input logic [7:0] v);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cur_unit = v;
	endtask

	task automatic push_header(input logic [15:0] len, input logic [7:0] u);
		frame_q.delete();
		repeat (4) frame_q.push_back(8'h00);
		frame_q.push_back(len[15:8]);
		frame_q.push_back(len[7:0]);
		frame_q.push_back(u);
	endtask

	task automatic build_read(input int n, input logic [7:0] u);
		push_header(16'(3 + 2 * n), u);
		frame_q.push_back(mtrc_pkg::FN_READ);
		frame_q.push_back(8'(2 * n));
		repeat (2 * n) begin
			case ($urandom_range(0, 7))
				0: frame_q.push_back(8'h00);
				1: frame_q.push_back(8'hFF);
				default: frame_q.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic build_write(input logic [15:0] addr, input logic [6:0] cnt,
			input logic [7:0] u);
		push_header(16'd6, u);
		frame_q.push_back(mtrc_pkg::FN_WRITE);
		frame_q.push_back(addr[15:8]);
		frame_q.push_back(addr[7:0]);
		frame_q.push_back(8'h00);
		frame_q.push_back({1'b0, cnt});
	endtask

	task automatic build_exc(input logic [7:0] fn, input logic [7:0] code,
			input logic [7:0] u);
		push_header(16'd3, u);
		frame_q.push_back(fn | mtrc_pkg::EXC_BIT);
		frame_q.push_back(code);
	endtask

	task automatic corrupt_frame();
		int i;
		case ($urandom_range(0, 5))
			0: begin
				i = $urandom_range(0, frame_q.size() - 1);
				frame_q[i] = frame_q[i] ^ 8'($urandom_range(1, 255));
			end
			1: begin
				i = $urandom_range(1, frame_q.size() - 1);
				while (frame_q.size() > i) void'(frame_q.pop_back());
			end
			2: repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
			3: frame_q[$urandom_range(0, 3)] = 8'($urandom_range(1, 255));
			4: frame_q[6] = 8'($urandom_range(0, 255));
			default: frame_q[7] = 8'($urandom_range(0, 255));
		endcase
	endtask

	task automatic random_frame();
		int k;
		int n;
		int r;
		logic [7:0]  fn;
		logic [7:0]  u;
		logic [15:0] addr;
		logic [6:0]  cnt;
		bit          mixed;
		k = $urandom_range(0, 99);
		u = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : cur_unit;
		addr = 16'($urandom_range(0, 65535));
		cnt = 7'($urandom_range(1, 125));
		fn = $urandom_range(0, 1) ? mtrc_pkg::FN_READ : mtrc_pkg::FN_WRITE;
		if (k < 42) begin
			n = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 125) : $urandom_range(1, 8);
			fn = mtrc_pkg::FN_READ;
			cnt = 7'(n);
			build_read(n, u);
		end else if (k < 67) begin
			fn = mtrc_pkg::FN_WRITE;
			build_write(addr, cnt, u);
		end else if (k < 77) begin
			build_exc(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 127)) : fn,
				($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(0, 255)), u);
		end else begin
			frame_q.delete();
			n = (k < 85) ? $urandom_range(1, 8) : $urandom_range(1, 24);
			repeat (n) frame_q.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
		end
		if (k < 77 && $urandom_range(0, 99) < 30) corrupt_frame();
		r = $urandom_range(0, 99);
		if (r < 5)
			fn = 8'($urandom_range(0, 255));
		else if (r < 8)
			cnt = '0;
		else if (r < 14)
			cnt = 7'($urandom_range(0, 125));
		else if (r < 18)
			addr = addr ^ 16'(1 << $urandom_range(0, 15));
		mixed = ($urandom_range(0, 99) < 6);
		send_frame(fn, addr, cnt, mixed);
	endtask

	initial begin
		logic [7:0] v;
		sb = new();
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cur_unit = mtrc_pkg::UNIT_ID_RESET;
		items_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// clean read of one register, all ones
		push_header(16'd5, cur_unit);
		frame_q.push_back(mtrc_pkg::FN_READ);
		frame_q.push_back(8'h02);
		frame_q.push_back(8'hFF);
		frame_q.push_back(8'hFF);
		send_frame(mtrc_pkg::FN_READ, 16'hFFFF, 7'd1, 1'b0);
		// exception frame carrying a zero code
		build_exc(mtrc_pkg::FN_READ, 8'h00, cur_unit);
		send_frame(mtrc_pkg::FN_READ, 16'h0000, 7'd125, 1'b0);
		// unsupported function, zero count, then a short frame
		frame_q.delete();
		frame_q.push_back(8'hFF);
		send_frame(8'hFF, 16'h0000, 7'd125, 1'b0);
		send_frame(mtrc_pkg::FN_READ, 16'h1234, 7'd0, 1'b0);
		frame_q.delete();
		repeat (3) frame_q.push_back(8'h00);
		send_frame(mtrc_pkg::FN_WRITE, 16'h8000, 7'd1, 1'b0);

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				v = (ph == 1) ? 8'h00 : (ph == 2) ? 8'hFF :
					(ph == 3) ? 8'($urandom_range(1, 254)) : mtrc_pkg::UNIT_ID_RESET;
				write_unit(v);
			end
			idle_on = (ph != 3);
			if (ph == 2) begin
				build_read(125, cur_unit);
				send_frame(mtrc_pkg::FN_READ, 16'h0000, 7'd125, 1'b0);
				// overlong frame, tail past the byte limit
				build_read(125, cur_unit);
				repeat ($urandom_range(3, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
				send_frame(mtrc_pkg::FN_READ, 16'h0000, 7'd125, 1'b0);
			end
			while (items_sent < (ph + 1) * ITEMS_PER_PHASE) begin
				random_frame();
				if ($urandom_range(0, 9) == 0) drain();
			end
		end

		drain();
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
